// ===== sv/rtppkt_pkg.sv =====
package rtppkt_pkg;

   // Chunk length counter width (8 to 32)
   localparam int LENGTH_BITS   = 24;
   localparam int CHUNK_LEN_W   = 24;
   localparam int PAYLOAD_BITS  = 11;
   localparam int PLEN_BITS     = 12;
   localparam int SEQ_BITS      = 16;
   localparam int PT_BITS       = 7;
   localparam int WORD_BITS     = 32;
   localparam int ADDR_BITS     = 4;
   localparam int CMP_BITS      = (LENGTH_BITS > PAYLOAD_BITS) ? LENGTH_BITS : PAYLOAD_BITS;

   localparam int HDR_BYTES     = 12;
   localparam int HDR_IDX_BITS  = 4;

   localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_CEIL = 11'd2036;
   localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MIN  = 11'd1;

   localparam logic [PT_BITS-1:0]      PT_RESET     = 7'd96;
   localparam logic [WORD_BITS-1:0]    SSRC_RESET   = 32'd999999999;
   localparam logic [SEQ_BITS-1:0]     SEQ_RESET    = 16'd0;
   localparam logic [PAYLOAD_BITS-1:0] MAXPL_RESET  = 11'd1388;

   localparam logic [7:0]              RTP_VERSION_BYTE = 8'h80;

   typedef enum logic [1:0] {
      REG_PAYLOAD_TYPE   = 2'd0,
      REG_SOURCE_ID      = 2'd1,
      REG_START_SEQUENCE = 2'd2,
      REG_MAX_PAYLOAD    = 2'd3
   } reg_index_type;

   typedef enum logic {
      ITEM_CHUNK_START = 1'b0,
      ITEM_DATA_BYTE   = 1'b1
   } item_kind_type;

endpackage

// ===== sv/rtp_payload_packetizer.sv =====
// Channel   Direction  Handshake              Beat contents
// req_*     in         req_valid / req_ready  chunk start descriptor or one payload byte
// rsp_*     out        rsp_valid / rsp_ready  one RTP packet byte (header or payload)
// csr       in/out     psel/penable (APB)     four 32-bit registers at 0x0, 0x4, 0x8, 0xC
//
// Flow: a chunk start is taken at once, and a payload byte inside a packet goes out as one
//   beat; the first payload byte of a packet goes out behind the 12 header beats, one beat per
//   cycle while rsp_ready allows, out of the single result register. Surplus bytes are dropped.
// Reset: synchronous, active high; clears both beat registers and the chunk state and
//   returns the registers to their defaults.
// Stalls: a one-entry input register and the result register part the two sides, so one
//   request beat is taken while a result beat waits on rsp_ready.
module rtp_payload_packetizer
   import rtppkt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [CHUNK_LEN_W-1:0]   req_chunk_length,
   input  logic [WORD_BITS-1:0]     req_chunk_timestamp,
   input  logic                     req_end_of_frame,
   input  logic [7:0]               req_data_byte,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_header,
   output logic [PLEN_BITS-1:0]     rsp_packet_length,
   output logic                     rsp_packet_end,
   output logic                     rsp_run_last,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_BITS-1:0]     paddr,
   input  logic [WORD_BITS-1:0]     pwdata,
   output logic [WORD_BITS-1:0]     prdata,
   output logic                     pready
);

   // ---------------------------------------------------------------- registers
   logic [PT_BITS-1:0]       payload_type_ff;
   logic [WORD_BITS-1:0]     source_id_ff;
   logic [SEQ_BITS-1:0]      start_seq_ff;
   logic [PAYLOAD_BITS-1:0]  max_payload_ff;

   logic                     csr_wr;
   reg_index_type            csr_idx;

   // ---------------------------------------------------------------- input beat register
   logic                     in_valid_ff;
   logic                     in_type_ff;
   logic [CHUNK_LEN_W-1:0]   in_len_ff;
   logic [WORD_BITS-1:0]     in_ts_ff;
   logic                     in_eof_ff;
   logic [7:0]               in_byte_ff;

   // ---------------------------------------------------------------- chunk state
   logic [SEQ_BITS-1:0]      seq_ff,  seq_in;
   logic [LENGTH_BITS-1:0]   rem_ff,  rem_in;
   logic [PAYLOAD_BITS-1:0]  fill_ff, fill_in;
   logic [WORD_BITS-1:0]     ts_ff,   ts_in;
   logic                     eof_ff,  eof_in;
   logic [PAYLOAD_BITS-1:0]  size_ff, size_in;
   logic [HDR_IDX_BITS-1:0]  hdr_idx_ff, hdr_idx_in;

   // ---------------------------------------------------------------- result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff,  rsp_byte_in;
   logic                     rsp_hdr_ff,   rsp_hdr_in;
   logic [PLEN_BITS-1:0]     rsp_plen_ff,  rsp_plen_in;
   logic                     rsp_pend_ff,  rsp_pend_in;
   logic                     rsp_last_ff,  rsp_last_in;

   // ---------------------------------------------------------------- datapath
   logic                     out_adv;
   logic                     in_take;
   logic                     emit;
   logic                     is_data;
   logic                     rem_zero;
   logic                     pkt_start;
   logic                     hdr_phase;
   logic [PAYLOAD_BITS-1:0]  cap;
   logic [PAYLOAD_BITS-1:0]  new_size;
   logic [PAYLOAD_BITS-1:0]  use_size;
   logic                     marker;
   logic [7:0]               hdr_byte;
   logic [PLEN_BITS-1:0]     plen;
   logic                     pend;
   logic [PLEN_BITS-1:0]     fill_next;

   // Configuration port: writes complete in the access phase, no wait states
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         REG_PAYLOAD_TYPE:   prdata = WORD_BITS'(payload_type_ff);
         REG_SOURCE_ID:      prdata = source_id_ff;
         REG_START_SEQUENCE: prdata = WORD_BITS'(start_seq_ff);
         REG_MAX_PAYLOAD:    prdata = WORD_BITS'(max_payload_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_type_ff <= PT_RESET;
         source_id_ff    <= SSRC_RESET;
         start_seq_ff    <= SEQ_RESET;
         max_payload_ff  <= MAXPL_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PAYLOAD_TYPE:   payload_type_ff <= pwdata[PT_BITS-1:0];
            REG_SOURCE_ID:      source_id_ff    <= pwdata;
            REG_START_SEQUENCE: start_seq_ff    <= pwdata[SEQ_BITS-1:0];
            REG_MAX_PAYLOAD:    max_payload_ff  <= pwdata[PAYLOAD_BITS-1:0];
            default:            ;
         endcase
      end
   end

   // Classify the held beat
   assign is_data   = in_valid_ff && (in_type_ff == ITEM_DATA_BYTE);
   assign rem_zero  = (rem_ff == '0);
   assign pkt_start = (fill_ff == '0);
   assign hdr_phase = pkt_start && (hdr_idx_ff != HDR_IDX_BITS'(HDR_BYTES));
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign emit      = is_data && !rem_zero && out_adv;

   // Consume: chunk starts and surplus bytes at once, data bytes once their beat goes out
   assign in_take   = in_valid_ff && (!is_data || rem_zero || (out_adv && !hdr_phase));
   assign req_ready = !in_valid_ff || in_take;

   // Payload cap, clamped to 1..2036, then the size of a packet that starts now
   always_comb begin
      cap = max_payload_ff;
      if (cap == '0) begin
         cap = PAYLOAD_MIN;
      end
      if (cap > PAYLOAD_CEIL) begin
         cap = PAYLOAD_CEIL;
      end
   end

   assign new_size = (CMP_BITS'(rem_ff) < CMP_BITS'(cap)) ? PAYLOAD_BITS'(rem_ff) : cap;
   assign marker   = eof_ff && (CMP_BITS'(new_size) == CMP_BITS'(rem_ff));
   assign use_size = pkt_start ? new_size : size_ff;
   assign plen     = PLEN_BITS'(use_size) + PLEN_BITS'(HDR_BYTES);
   assign fill_next = PLEN_BITS'(fill_ff) + PLEN_BITS'(1);
   assign pend     = fill_next >= PLEN_BITS'(use_size);

   // Header byte select, big-endian fields
   always_comb begin
      unique case (hdr_idx_ff)
         4'd0:    hdr_byte = RTP_VERSION_BYTE;
         4'd1:    hdr_byte = {marker, payload_type_ff};
         4'd2:    hdr_byte = seq_ff[15:8];
         4'd3:    hdr_byte = seq_ff[7:0];
         4'd4:    hdr_byte = ts_ff[31:24];
         4'd5:    hdr_byte = ts_ff[23:16];
         4'd6:    hdr_byte = ts_ff[15:8];
         4'd7:    hdr_byte = ts_ff[7:0];
         4'd8:    hdr_byte = source_id_ff[31:24];
         4'd9:    hdr_byte = source_id_ff[23:16];
         4'd10:   hdr_byte = source_id_ff[15:8];
         4'd11:   hdr_byte = source_id_ff[7:0];
         default: hdr_byte = '0;
      endcase
   end

   // Next chunk state
   always_comb begin
      seq_in     = seq_ff;
      rem_in     = rem_ff;
      fill_in    = fill_ff;
      ts_in      = ts_ff;
      eof_in     = eof_ff;
      size_in    = size_ff;
      hdr_idx_in = hdr_idx_ff;

      if (in_valid_ff && (in_type_ff == ITEM_CHUNK_START)) begin
         // Abandon any open chunk and load the new one
         rem_in     = LENGTH_BITS'(in_len_ff);
         ts_in      = in_ts_ff;
         eof_in     = in_eof_ff;
         fill_in    = '0;
         size_in    = '0;
         hdr_idx_in = '0;
      end else if (emit) begin
         if (hdr_phase) begin
            hdr_idx_in = hdr_idx_ff + HDR_IDX_BITS'(1);
         end else begin
            if (pkt_start) begin
               size_in = new_size;
               seq_in  = seq_ff + SEQ_BITS'(1);
            end
            hdr_idx_in = '0;
            rem_in     = rem_ff - LENGTH_BITS'(1);
            fill_in    = pend ? '0 : fill_next[PAYLOAD_BITS-1:0];
         end
      end

      // Start sequence write reloads the counter (the user must write it while idle; the block does not enforce this)
      if (csr_wr && (csr_idx == REG_START_SEQUENCE)) begin
         seq_in = pwdata[SEQ_BITS-1:0];
      end
   end

   // Next result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_hdr_in   = rsp_hdr_ff;
      rsp_plen_in  = rsp_plen_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_plen_in  = plen;
         if (hdr_phase) begin
            rsp_byte_in = hdr_byte;
            rsp_hdr_in  = 1'b1;
            rsp_pend_in = 1'b0;
            rsp_last_in = 1'b0;
         end else begin
            rsp_byte_in = in_byte_ff;
            rsp_hdr_in  = 1'b0;
            rsp_pend_in = pend;
            rsp_last_in = 1'b1;
         end
      end
   end

   // Hold the request beat until it is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff <= req_type;
         in_len_ff  <= req_chunk_length;
         in_ts_ff   <= req_chunk_timestamp;
         in_eof_ff  <= req_end_of_frame;
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_RESET;
         rem_ff       <= '0;
         fill_ff      <= '0;
         ts_ff        <= '0;
         eof_ff       <= 1'b0;
         size_ff      <= '0;
         hdr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rem_ff       <= rem_in;
         fill_ff      <= fill_in;
         ts_ff        <= ts_in;
         eof_ff       <= eof_in;
         size_ff      <= size_in;
         hdr_idx_ff   <= hdr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_hdr_ff  <= rsp_hdr_in;
      rsp_plen_ff <= rsp_plen_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_is_header     = rsp_hdr_ff;
   assign rsp_packet_length = rsp_plen_ff;
   assign rsp_packet_end    = rsp_pend_ff;
   assign rsp_run_last      = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_hdr_idx_range: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff <= HDR_IDX_BITS'(HDR_BYTES))
      else $error("header index past header length");

   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hdr_ff |-> !rsp_last_ff && !rsp_pend_ff)
      else $error("header beat marked last or packet end");

   a_fill_below_size: assert property (@(posedge clock) disable iff (reset)
      fill_ff != '0 |-> fill_ff < size_ff)
      else $error("packet fill reached packet size without closing");

   a_hdr_only_at_start: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff != '0 |-> fill_ff == '0 && rem_ff != '0)
      else $error("header in progress outside a packet start");

endmodule

// ===== dv/rtp_packet_checker.sv =====
module rtp_packet_checker
   import rtppkt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_type,
   input  logic [CHUNK_LEN_W-1:0] req_chunk_length,
   input  logic [WORD_BITS-1:0]   req_chunk_timestamp,
   input  logic                   req_end_of_frame,
   input  logic [7:0]             req_data_byte,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_out_byte,
   input  logic                   rsp_is_header,
   input  logic [PLEN_BITS-1:0]   rsp_packet_length,
   input  logic                   rsp_packet_end,
   input  logic                   rsp_run_last,

   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   pready,
   input  logic [ADDR_BITS-1:0]   paddr,
   input  logic [WORD_BITS-1:0]   pwdata,

   output int                     mismatches,
   output int                     beats_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 is_header;
      logic [PLEN_BITS-1:0] packet_length;
      logic                 packet_end;
      logic                 run_last;
   } packet_byte_type;

   logic [PT_BITS-1:0]      pt_reg;
   logic [WORD_BITS-1:0]    ssrc_reg;
   logic [SEQ_BITS-1:0]     start_seq_reg;
   logic [PAYLOAD_BITS-1:0] max_pl_reg;

   logic [SEQ_BITS-1:0]     seq_count;
   logic [LENGTH_BITS-1:0]  chunk_left;
   logic [PAYLOAD_BITS-1:0] fill_count;
   logic [WORD_BITS-1:0]    chunk_stamp;
   logic                    chunk_eof;
   logic [PAYLOAD_BITS-1:0] packet_size;

   packet_byte_type         owed_bytes[$];
   int                      error_tally = 0;
   int                      beat_no = 0;

   assign mismatches = error_tally;

   task automatic flag_mismatch(string msg);
      error_tally++;
      // keep counting, but hold the log to a readable length
      if (error_tally <= 40)
         $display("%0t rtp_packet_checker: result beat %0d: %s", $time, beat_no, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic write_register(reg_index_type idx, logic [WORD_BITS-1:0] value);
      case (idx)
         REG_PAYLOAD_TYPE:   pt_reg = value[PT_BITS-1:0];
         REG_SOURCE_ID:      ssrc_reg = value;
         REG_START_SEQUENCE: begin
            start_seq_reg = value[SEQ_BITS-1:0];
            seq_count     = value[SEQ_BITS-1:0];
         end
         REG_MAX_PAYLOAD:    max_pl_reg = value[PAYLOAD_BITS-1:0];
         default: ;
      endcase
   endtask

   // Work out the packet bytes that one request beat produces.
   task automatic packetize(item_kind_type kind, logic [CHUNK_LEN_W-1:0] length,
                            logic [WORD_BITS-1:0] stamp, logic eof, logic [7:0] data);
      logic [PAYLOAD_BITS-1:0] cap;
      logic [PLEN_BITS-1:0]    plen;
      logic                    marker;
      logic                    last_of_packet;
      logic [7:0]              hdr [HDR_BYTES];
      if (kind == ITEM_CHUNK_START) begin
         chunk_left  = LENGTH_BITS'(length);
         chunk_stamp = stamp;
         chunk_eof   = eof;
         fill_count  = '0;
         packet_size = '0;
         return;
      end
      // drop bytes beyond the chunk
      if (chunk_left == '0)
         return;
      if (fill_count == '0) begin
         cap = (max_pl_reg == '0) ? PAYLOAD_MIN :
               (max_pl_reg > PAYLOAD_CEIL) ? PAYLOAD_CEIL : max_pl_reg;
         packet_size = (CMP_BITS'(chunk_left) < CMP_BITS'(cap)) ?
                       PAYLOAD_BITS'(chunk_left) : cap;
         marker = chunk_eof && (CMP_BITS'(packet_size) == CMP_BITS'(chunk_left));
         hdr[0]  = RTP_VERSION_BYTE;
         hdr[1]  = {marker, pt_reg};
         hdr[2]  = seq_count[15:8];
         hdr[3]  = seq_count[7:0];
         hdr[4]  = chunk_stamp[31:24];
         hdr[5]  = chunk_stamp[23:16];
         hdr[6]  = chunk_stamp[15:8];
         hdr[7]  = chunk_stamp[7:0];
         hdr[8]  = ssrc_reg[31:24];
         hdr[9]  = ssrc_reg[23:16];
         hdr[10] = ssrc_reg[15:8];
         hdr[11] = ssrc_reg[7:0];
         seq_count++;
         plen = PLEN_BITS'(packet_size) + PLEN_BITS'(HDR_BYTES);
         foreach (hdr[i])
            owed_bytes.push_back(packet_byte_type'{hdr[i], 1'b1, plen, 1'b0, 1'b0});
      end
      plen = PLEN_BITS'(packet_size) + PLEN_BITS'(HDR_BYTES);
      fill_count++;
      chunk_left--;
      last_of_packet = (fill_count >= packet_size);
      owed_bytes.push_back(packet_byte_type'{data, 1'b0, plen, last_of_packet, 1'b1});
      if (last_of_packet)
         fill_count = '0;
   endtask

   task automatic check_beat();
      packet_byte_type want;
      beat_no++;
      if (owed_bytes.size() == 0) begin
         flag_mismatch($sformatf("byte %02h arrived with nothing expected", rsp_out_byte));
         return;
      end
      want = owed_bytes.pop_front();
      check_field("out_byte", rsp_out_byte, want.out_byte);
      check_field("is_header", rsp_is_header, want.is_header);
      check_field("packet_length", rsp_packet_length, want.packet_length);
      check_field("packet_end", rsp_packet_end, want.packet_end);
      check_field("run_last", rsp_run_last, want.run_last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pt_reg        = PT_RESET;
         ssrc_reg      = SSRC_RESET;
         start_seq_reg = SEQ_RESET;
         max_pl_reg    = MAXPL_RESET;
         seq_count     = SEQ_RESET;
         chunk_left    = '0;
         fill_count    = '0;
         chunk_stamp   = '0;
         chunk_eof     = 1'b0;
         packet_size   = '0;
         owed_bytes.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            write_register(reg_index_type'(paddr[ADDR_BITS-1:2]), pwdata);
         if (rsp_valid && rsp_ready)
            check_beat();
         if (req_valid && req_ready)
            packetize(item_kind_type'(req_type), req_chunk_length, req_chunk_timestamp,
                      req_end_of_frame, req_data_byte);
      end
      beats_owed <= owed_bytes.size();
   end

endmodule

// ===== dv/tb_rtp_payload_packetizer.sv =====
module tb_rtp_payload_packetizer import rtppkt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Random part stops once this many request beats have been sent that the block acts on.
   localparam int RANDOM_ITEMS  = 500;
   // Cycles with no beat on any port before the run is declared hung.
   localparam int IDLE_LIMIT    = 1000;
   // Quiet cycles after the last expected result before touching registers or ending:
   // covers a first payload byte and its header beats still in flight, plus a margin.
   localparam int SETTLE_CYCLES = 16;
   // One chunk longer than the payload ceiling, so its first packet is sized at the ceiling.
   localparam int BIG_CHUNK     = 2040;
   // Opening payload bytes sent from that chunk.
   localparam int BIG_HEAD      = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_type = ITEM_CHUNK_START;
   logic [CHUNK_LEN_W-1:0] req_chunk_length = '0;
   logic [WORD_BITS-1:0]   req_chunk_timestamp = '0;
   logic                   req_end_of_frame = 1'b0;
   logic [7:0]             req_data_byte = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_is_header;
   logic [PLEN_BITS-1:0]   rsp_packet_length;
   logic                   rsp_packet_end;
   logic                   rsp_run_last;

   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [ADDR_BITS-1:0]   paddr = '0;
   logic [WORD_BITS-1:0]   pwdata = '0;
   logic [WORD_BITS-1:0]   prdata;
   logic                   pready;

   int                     mismatches;
   int                     beats_owed;
   int                     quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rtp_payload_packetizer dut (.*);

   // Checker sits beside the block: it predicts every packet byte and counts mismatches.
   rtp_packet_checker watch (.*);

   // Mostly the shortest pauses, some short ones, a few long ones.
   function automatic int pause_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 1;
      if (roll < 90)
         return $urandom_range(2, 4);
      return $urandom_range(10, 40);
   endfunction

   // Present one request beat and hold it until taken. Enter and leave on a rising edge;
   // valid stays high on exit so a back-to-back beat needs no second assignment.
   task automatic send_beat(item_kind_type kind, logic [CHUNK_LEN_W-1:0] length,
                            logic [WORD_BITS-1:0] stamp, logic eof, logic [7:0] data,
                            bit gappy);
      int gap;
      gap = (gappy && $urandom_range(0, 99) >= 65) ? pause_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_chunk_length    <= length;
      req_chunk_timestamp <= stamp;
      req_end_of_frame    <= eof;
      req_data_byte       <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // Chunk start beat; the unused byte field carries noise.
   task automatic send_start(logic [CHUNK_LEN_W-1:0] length, logic [WORD_BITS-1:0] stamp,
                             logic eof, bit gappy);
      send_beat(ITEM_CHUNK_START, length, stamp, eof, 8'($urandom), gappy);
   endtask

   // Data byte beat; the descriptor fields carry noise the block must ignore.
   task automatic send_data(logic [7:0] data, bit gappy);
      send_beat(ITEM_DATA_BYTE, CHUNK_LEN_W'($urandom), $urandom, 1'($urandom), data, gappy);
   endtask

   // Drop valid, wait for every expected byte, then let a possible in-flight beat settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands on the edge with pready high.
   // Drop psel before returning so a following write starts its own setup phase.
   task automatic csr_write(reg_index_type idx, logic [WORD_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: long stretches always ready, otherwise short bursts broken by stalls.
   initial begin
      int hold;
      int stall;
      forever begin
         if ($urandom_range(0, 9) < 3) begin
            hold  = $urandom_range(20, 120);
            stall = 0;
         end else begin
            hold  = $urandom_range(1, 6);
            stall = pause_length();
         end
         repeat (hold) begin
            @(posedge clock);
            rsp_ready <= 1'b1;
         end
         repeat (stall) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Hang detector: any beat on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_rtp_payload_packetizer: FAIL");
         $finish;
      end
   end

   initial begin
      int                     useful_items;
      int                     open_bytes;
      int                     n_chunks;
      int                     nbytes;
      int                     pick;
      bit                     gappy;
      logic [CHUNK_LEN_W-1:0] len;
      logic [WORD_BITS-1:0]   cap_word;

      useful_items = 0;
      open_bytes   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, default registers ---
      // Short frame end: extreme byte values and an all-ones timestamp, marker set.
      send_start(24'd3, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_data(8'h00, 1'b0);
      send_data(8'hFF, 1'b0);
      send_data(8'hA5, 1'b1);
      // Surplus byte with no chunk open: dropped.
      send_data(8'h5A, 1'b0);
      // Zero-length chunk: nothing goes out, its byte is surplus.
      send_start(24'd0, 32'h1234_5678, 1'b1, 1'b0);
      send_data(8'h3C, 1'b0);
      // Longest chunk, abandoned after two bytes by a new start that opens a fresh packet.
      send_start(24'hFF_FFFF, 32'h0, 1'b0, 1'b0);
      send_data(8'h01, 1'b0);
      send_data(8'hFE, 1'b0);
      send_start(24'd2, 32'h0F0F_0F0F, 1'b0, 1'b0);
      send_data(8'h81, 1'b0);
      send_data(8'h7E, 1'b0);
      drain_results();

      // All-ones type and SSRC, cap of zero (read as one byte per packet), and a start
      // sequence at the top so the three packets wrap the counter.
      csr_write(REG_PAYLOAD_TYPE, 32'h7F);
      csr_write(REG_SOURCE_ID, 32'hFFFF_FFFF);
      csr_write(REG_START_SEQUENCE, 32'hFFFF);
      csr_write(REG_MAX_PAYLOAD, 32'd0);
      send_start(24'd3, 32'hAAAA_AAAA, 1'b1, 1'b0);
      repeat (3) send_data(8'($urandom), 1'b0);
      drain_results();

      // Zero type and SSRC, cap above the ceiling; open a five-byte packet and stop halfway.
      csr_write(REG_PAYLOAD_TYPE, 32'h0);
      csr_write(REG_SOURCE_ID, 32'h0);
      csr_write(REG_MAX_PAYLOAD, 32'd2047);
      send_start(24'd5, 32'h5555_5555, 1'b1, 1'b0);
      repeat (2) send_data(8'($urandom), 1'b0);
      drain_results();
      // Shrink the cap mid-packet: the open packet keeps its size. The new start
      // sequence only shows on the next packet.
      csr_write(REG_MAX_PAYLOAD, 32'd1);
      csr_write(REG_START_SEQUENCE, 32'h8000);
      repeat (3) send_data(8'($urandom), 1'b0);

      // --- random part: phases of chunks, mostly well formed ---
      while (useful_items < RANDOM_ITEMS) begin
         // Settle and retune in about two phases of three; otherwise stream straight on.
         if ($urandom_range(0, 2) != 0) begin
            drain_results();
            if ($urandom_range(0, 1))
               csr_write(REG_PAYLOAD_TYPE, $urandom);
            if ($urandom_range(0, 2) == 0)
               csr_write(REG_SOURCE_ID, $urandom);
            if ($urandom_range(0, 2) == 0)
               csr_write(REG_START_SEQUENCE, $urandom);
            if ($urandom_range(0, 1)) begin
               // upper bits are don't-care to the register
               cap_word = $urandom_range(0, 1) ? $urandom : 32'd0;
               case ($urandom_range(0, 9))
                  0:       cap_word[PAYLOAD_BITS-1:0] = '0;
                  1:       cap_word[PAYLOAD_BITS-1:0] = 11'd1;
                  2:       cap_word[PAYLOAD_BITS-1:0] = 11'd2047;
                  3:       cap_word[PAYLOAD_BITS-1:0] = PAYLOAD_CEIL;
                  4, 5, 6: cap_word[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'($urandom_range(2, 8));
                  default: cap_word[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'($urandom_range(1, 48));
               endcase
               csr_write(REG_MAX_PAYLOAD, cap_word);
            end
         end
         gappy = ($urandom_range(0, 3) != 0);

         // Finish a chunk left open by the last phase, often under new registers.
         if (open_bytes > 0 && $urandom_range(0, 1)) begin
            repeat (open_bytes) send_data(8'($urandom), gappy);
            useful_items += open_bytes;
         end
         open_bytes = 0;

         n_chunks = $urandom_range(1, 6);
         repeat (n_chunks) begin
            pick = $urandom_range(0, 99);
            open_bytes = 0;
            if (pick < 72) begin
               // complete chunk
               len    = CHUNK_LEN_W'($urandom_range(1, 40));
               nbytes = int'(len);
            end else if (pick < 80) begin
               // empty chunk, any bytes after it are surplus
               len    = '0;
               nbytes = $urandom_range(0, 2);
            end else if (pick < 94) begin
               // truncated chunk, sometimes with a length spread over all 24 bits
               len = $urandom_range(0, 1) ? CHUNK_LEN_W'($urandom)
                                          : CHUNK_LEN_W'($urandom_range(2, 60));
               if (len < 2)
                  len = 2;
               nbytes     = $urandom_range(0, (len > 30) ? 30 : int'(len) - 1);
               open_bytes = (int'(len) - nbytes > 30) ? 30 : int'(len) - nbytes;
            end else begin
               // overfilled chunk, the tail is surplus
               len    = CHUNK_LEN_W'($urandom_range(1, 20));
               nbytes = int'(len) + $urandom_range(1, 3);
            end
            send_start(len, $urandom, 1'($urandom), gappy);
            repeat (nbytes) send_data(8'($urandom), gappy);
            useful_items += 1 + ((nbytes < int'(len)) ? nbytes : int'(len));
         end
      end

      // Cap above the ceiling with a chunk longer than the ceiling: the opening packet
      // is sized at 2036 payload bytes and carries no marker. Send its first bytes only.
      drain_results();
      csr_write(REG_MAX_PAYLOAD, 32'd2047);
      send_start(CHUNK_LEN_W'(BIG_CHUNK), $urandom, 1'b1, 1'b0);
      repeat (BIG_HEAD) send_data(8'($urandom), 1'b0);

      // Wait out every expected byte, then a quiet tail for strays.
      drain_results();
      if (mismatches == 0 && beats_owed == 0)
         $display("tb_rtp_payload_packetizer: PASS");
      else
         $display("tb_rtp_payload_packetizer: FAIL");
      $finish;
   end

endmodule
